### sv/assert_macros.svh
// Assertion macros for the RTL of the PNG stream encoder (included by pngse_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### sv/pngse_pkg.sv
// Types, constants and the CRC-32 byte function of the PNG stream encoder
`timescale 1ns / 1ps
package pngse_pkg;

    localparam int CFG_W   = 13;
    localparam int TOTAL_W = 2 * CFG_W + 2;
    localparam int BLK_W   = 16;
    localparam int IDX_W   = 6;

    localparam logic        REG_WIDTH  = 1'b0;
    localparam logic        REG_HEIGHT = 1'b1;

    localparam logic [9:0]  WIDTH_RESET  = 10'd640;
    localparam logic [8:0]  HEIGHT_RESET = 9'd480;

    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [15:0] STORED_MAX = 16'hFFFF;
    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

    localparam logic [IDX_W-1:0] HEAD_LAST = 6'd42;
    localparam logic [IDX_W-1:0] TAIL_LAST = 6'd19;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_RAW,
        PH_TAIL
    } back_phase_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       first;
        logic       row_start;
        logic       last;
    } pix_entry_t;

    typedef struct packed {
        logic [CFG_W-1:0]   width;
        logic [CFG_W-1:0]   height;
        logic [TOTAL_W-1:0] total;
        logic [31:0]        idat_len;
    } geom_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### sv/pngse_if.sv
// Channel interfaces: pixel input and byte output
`timescale 1ns / 1ps
interface pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink (input valid, red, green, blue, output ready);
endinterface

interface byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       file_last;

    modport source (output valid, out_byte, run_last, file_last, input ready);
    modport sink (input valid, out_byte, run_last, file_last, output ready);
endinterface

### sv/png_stored_stream_encoder.sv
// Top level of the PNG stream encoder: front end, item queue, byte sequencer
//
// channel   dir   handshake      payload
// pixels    in    valid/ready    red, green, blue
// stream    out   valid/ready    out_byte, run_last, file_last
// cfg       in    cfg_we         cfg_index, cfg_data
//
// The byte sequencer's output register sets the rate: one byte per cycle while
// the stream is ready and items are queued. A pixel is 3 or 4 bytes, plus 5 per
// stored block header, 43 more on a file's first pixel and 20 more on its last.
// The pixel queue keeps taking items while the output stalls, until it is full.
// Reset or any register write restarts the file on the next pixel.
`timescale 1ns / 1ps
module png_stored_stream_encoder
    import pngse_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    pixel_if.sink            pixels,
    byte_if.source           stream
);

    logic       q_full, push, pop, q_valid, restart;
    pix_entry_t push_entry, q_entry;
    geom_t      geom;

    pngse_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixels     (pixels),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry),
        .geom       (geom),
        .restart    (restart)
    );

    pngse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .flush      (restart),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_entry    (q_entry)
    );

    pngse_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .geom    (geom),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .stream  (stream)
    );

endmodule

### sv/pngse_front.sv
// Front end: configuration, image geometry, pixel accept and classification
`timescale 1ns / 1ps
module pngse_front
    import pngse_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    pixel_if.sink            pixels,
    input  logic             q_full,
    output logic             push,
    output pix_entry_t       push_entry,
    output geom_t            geom,
    output logic             restart
);

    localparam int CNT_W = $clog2(MAX_DIMENSION);

    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [CFG_W-1:0]   w_eff, h_eff;
    logic [CFG_W-1:0]   w_eff_reg, h_eff_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [12:0]        blocks_reg;
    logic [31:0]        idat_len_reg;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [11:0]        quot;
    logic [16:0]        rem17;
    logic [12:0]        blocks_next;
    logic               accept, end_col, end_row;

    always_comb
    begin
        w_eff = width_reg;
        if (width_reg < CFG_W'(2))
            w_eff = CFG_W'(2);
        else if (32'(width_reg) > MAX_DIMENSION)
            w_eff = CFG_W'(MAX_DIMENSION);
        h_eff = height_reg;
        if (height_reg == '0)
            h_eff = CFG_W'(1);
        else if (32'(height_reg) > MAX_DIMENSION)
            h_eff = CFG_W'(MAX_DIMENSION);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(WIDTH_RESET);
            height_reg <= CFG_W'(HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ceil(total / 65535): 65536*q + lo = 65535*q + (lo + q)
    always_comb
    begin
        quot  = total_reg[TOTAL_W-1:16];
        rem17 = {1'b0, total_reg[15:0]} + {5'd0, quot};
        blocks_next = {1'b0, quot};
        if (rem17 >= {1'b0, STORED_MAX})
        begin
            blocks_next = blocks_next + 13'd1;
            rem17 = rem17 - {1'b0, STORED_MAX};
        end
        if (rem17 != '0)
            blocks_next = blocks_next + 13'd1;
    end

    // Geometry regs settle in order (eff sizes, total, blocks, idat_len) before use
    always_ff @(posedge clk)
    begin
        w_eff_reg    <= w_eff;
        h_eff_reg    <= h_eff;
        total_reg    <= TOTAL_W'(h_eff_reg)
                        * TOTAL_W'({2'b00, w_eff_reg} * 15'd3 + 15'd1);
        blocks_reg   <= blocks_next;
        idat_len_reg <= 32'd6 + {17'd0, blocks_reg, 2'b00} + {19'd0, blocks_reg}
                        + 32'(total_reg);
    end

    assign geom.width    = w_eff_reg;
    assign geom.height   = h_eff_reg;
    assign geom.total    = total_reg;
    assign geom.idat_len = idat_len_reg;

    assign pixels.ready = !q_full;
    assign accept       = pixels.valid && pixels.ready;
    assign restart      = cfg_we;

    assign end_col = (col_reg == CNT_W'(w_eff - CFG_W'(1)));
    assign end_row = (row_reg == CNT_W'(h_eff - CFG_W'(1)));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (end_col)
            begin
                col_next = '0;
                row_next = end_row ? '0 : row_reg + CNT_W'(1);
            end
            else
                col_next = col_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign push                 = accept;
    assign push_entry.red       = pixels.red;
    assign push_entry.green     = pixels.green;
    assign push_entry.blue      = pixels.blue;
    assign push_entry.first     = (col_reg == '0) && (row_reg == '0);
    assign push_entry.row_start = (col_reg == '0);
    assign push_entry.last      = end_col && end_row;

endmodule

### sv/pngse_queue.sv
// Short item queue between the front end and the byte sequencer
`timescale 1ns / 1ps
module pngse_queue
    import pngse_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       flush,
    input  logic       push,
    input  pix_entry_t push_entry,
    output logic       full,
    input  logic       pop,
    output logic       q_valid,
    output pix_entry_t q_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pix_entry_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
    endfunction

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (flush)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

### sv/pngse_back.sv
// Byte sequencer: chunk framing, stored blocks, CRC-32, Adler-32, output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pngse_back
    import pngse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       restart,
    input  geom_t      geom,
    input  logic       q_valid,
    input  pix_entry_t q_entry,
    output logic       pop,
    byte_if.source     stream
);

    back_phase_t        phase_reg, phase_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [2:0]         hdr_reg, hdr_next;
    logic [1:0]         sub_reg, sub_next;
    pix_entry_t         cur_reg;
    logic [31:0]        crc_reg;
    logic [15:0]        adler_lo_reg, adler_hi_reg;
    logic [TOTAL_W-1:0] raw_off_reg;
    logic [BLK_W-1:0]   blk_left_reg;
    logic               out_valid_reg, out_run_last_reg, out_file_last_reg;
    logic [7:0]         out_byte_reg;

    logic               adv, emit, crc_en, crc_init, item_done, file_done;
    logic               raw_emit, hdr_emit, item_fire, load;
    logic [7:0]         byte_v, raw_byte;
    logic [31:0]        crc_out, adler_word, w32, h32;
    logic [TOTAL_W-1:0] rem;
    logic [BLK_W-1:0]   blk_len;
    logic               blk_fin;
    logic [16:0]        lo_sum, lo_red, hi_sum, hi_red;

    function automatic logic [7:0] be_byte(input logic [31:0] w, input logic [1:0] sel);
        return w[8*(3-sel) +: 8];
    endfunction

    assign adv        = !out_valid_reg || stream.ready;
    assign crc_out    = ~crc_reg;
    assign adler_word = {adler_hi_reg, adler_lo_reg};
    assign w32        = 32'(geom.width);
    assign h32        = 32'(geom.height);

    // stored block header fields
    assign rem     = geom.total - raw_off_reg;
    assign blk_fin = (rem <= TOTAL_W'(STORED_MAX));
    assign blk_len = blk_fin ? rem[BLK_W-1:0] : STORED_MAX;

    always_comb
    begin
        unique case (sub_reg)
            2'd0:    raw_byte = 8'h00;
            2'd1:    raw_byte = cur_reg.red;
            2'd2:    raw_byte = cur_reg.green;
            default: raw_byte = cur_reg.blue;
        endcase
    end

    always_comb
    begin
        lo_sum = {1'b0, adler_lo_reg} + {9'd0, raw_byte};
        lo_red = (lo_sum >= ADLER_MOD) ? lo_sum - ADLER_MOD : lo_sum;
        hi_sum = {1'b0, adler_hi_reg} + lo_red;
        hi_red = (hi_sum >= ADLER_MOD) ? hi_sum - ADLER_MOD : hi_sum;
    end

    // byte selection and per-byte flags
    always_comb
    begin
        emit      = 1'b0;
        byte_v    = 8'h00;
        crc_en    = 1'b0;
        crc_init  = 1'b0;
        item_done = 1'b0;
        file_done = 1'b0;
        raw_emit  = 1'b0;
        hdr_emit  = 1'b0;
        unique case (phase_reg)
            PH_IDLE: ;
            PH_HEAD:
            begin
                emit     = 1'b1;
                crc_en   = ((idx_reg >= 6'd12) && (idx_reg <= 6'd28)) || (idx_reg >= 6'd37);
                crc_init = (idx_reg == 6'd12) || (idx_reg == 6'd37);
                priority if (idx_reg >= 6'd29 && idx_reg <= 6'd32)
                    byte_v = be_byte(crc_out, 2'(idx_reg - 6'd29));
                else if (idx_reg >= 6'd33 && idx_reg <= 6'd36)
                    byte_v = be_byte(geom.idat_len, 2'(idx_reg - 6'd33));
                else if (idx_reg >= 6'd16 && idx_reg <= 6'd19)
                    byte_v = be_byte(w32, idx_reg[1:0]);
                else if (idx_reg >= 6'd20 && idx_reg <= 6'd23)
                    byte_v = be_byte(h32, idx_reg[1:0]);
                else
                begin
                    unique case (idx_reg)
                        6'd0:    byte_v = 8'h89;
                        6'd1:    byte_v = 8'h50;
                        6'd2:    byte_v = 8'h4E;
                        6'd3:    byte_v = 8'h47;
                        6'd4:    byte_v = 8'h0D;
                        6'd5:    byte_v = 8'h0A;
                        6'd6:    byte_v = 8'h1A;
                        6'd7:    byte_v = 8'h0A;
                        6'd11:   byte_v = 8'd13;
                        6'd12:   byte_v = 8'h49;
                        6'd13:   byte_v = 8'h48;
                        6'd14:   byte_v = 8'h44;
                        6'd15:   byte_v = 8'h52;
                        6'd24:   byte_v = 8'd8;
                        6'd25:   byte_v = 8'd2;
                        6'd37:   byte_v = 8'h49;
                        6'd38:   byte_v = 8'h44;
                        6'd39:   byte_v = 8'h41;
                        6'd40:   byte_v = 8'h54;
                        6'd41:   byte_v = 8'h78;
                        6'd42:   byte_v = 8'h9C;
                        default: byte_v = 8'h00;
                    endcase
                end
            end
            PH_RAW:
            begin
                emit   = 1'b1;
                crc_en = 1'b1;
                if (blk_left_reg == '0)
                begin
                    hdr_emit = 1'b1;
                    unique case (hdr_reg)
                        3'd0:    byte_v = {7'd0, blk_fin};
                        3'd1:    byte_v = blk_len[7:0];
                        3'd2:    byte_v = blk_len[15:8];
                        3'd3:    byte_v = ~blk_len[7:0];
                        default: byte_v = ~blk_len[15:8];
                    endcase
                end
                else
                begin
                    raw_emit  = 1'b1;
                    byte_v    = raw_byte;
                    item_done = (sub_reg == 2'd3) && !cur_reg.last;
                end
            end
            PH_TAIL:
            begin
                emit     = 1'b1;
                crc_en   = (idx_reg <= 6'd3) || ((idx_reg >= 6'd12) && (idx_reg <= 6'd15));
                crc_init = (idx_reg == 6'd12);
                priority if (idx_reg <= 6'd3)
                    byte_v = be_byte(adler_word, idx_reg[1:0]);
                else if (idx_reg <= 6'd7 || idx_reg >= 6'd16)
                    byte_v = be_byte(crc_out, idx_reg[1:0]);
                else
                begin
                    unique case (idx_reg)
                        6'd12:   byte_v = 8'h49;
                        6'd13:   byte_v = 8'h45;
                        6'd14:   byte_v = 8'h4E;
                        6'd15:   byte_v = 8'h44;
                        default: byte_v = 8'h00;
                    endcase
                end
                item_done = (idx_reg == TAIL_LAST);
                file_done = (idx_reg == TAIL_LAST);
            end
            default: ;
        endcase
    end

    assign item_fire = adv && item_done;
    assign load      = q_valid && !restart && ((phase_reg == PH_IDLE) || item_fire);
    assign pop       = load;

    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        hdr_next   = hdr_reg;
        sub_next   = sub_reg;
        if (adv && emit)
        begin
            unique case (phase_reg)
                PH_HEAD:
                begin
                    if (idx_reg == HEAD_LAST)
                    begin
                        phase_next = PH_RAW;
                        idx_next   = '0;
                        hdr_next   = '0;
                        sub_next   = 2'd0;
                    end
                    else
                        idx_next = idx_reg + IDX_W'(1);
                end
                PH_RAW:
                begin
                    if (hdr_emit)
                        hdr_next = (hdr_reg == 3'd4) ? 3'd0 : hdr_reg + 3'd1;
                    else if (sub_reg == 2'd3)
                    begin
                        if (cur_reg.last)
                        begin
                            phase_next = PH_TAIL;
                            idx_next   = '0;
                        end
                    end
                    else
                        sub_next = sub_reg + 2'd1;
                end
                PH_TAIL:
                    idx_next = idx_reg + IDX_W'(1);
                default: ;
            endcase
        end
        if (item_fire)
            phase_next = PH_IDLE;
        if (load)
        begin
            phase_next = q_entry.first ? PH_HEAD : PH_RAW;
            idx_next   = '0;
            hdr_next   = '0;
            sub_next   = q_entry.row_start ? 2'd0 : 2'd1;
        end
        if (restart)
            phase_next = PH_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            hdr_reg   <= '0;
            sub_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            hdr_reg   <= hdr_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            cur_reg <= q_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= '1;
            adler_lo_reg <= 16'd1;
            adler_hi_reg <= '0;
            raw_off_reg  <= '0;
            blk_left_reg <= '0;
        end
        else
        begin
            if (restart)
                crc_reg <= '1;
            else if (adv && emit && crc_en)
                crc_reg <= crc_byte(crc_init ? '1 : crc_reg, byte_v);

            if (restart || (adv && file_done) || (load && q_entry.first))
            begin
                adler_lo_reg <= 16'd1;
                adler_hi_reg <= '0;
                raw_off_reg  <= '0;
                blk_left_reg <= '0;
            end
            else if (adv && raw_emit)
            begin
                adler_lo_reg <= lo_red[15:0];
                adler_hi_reg <= hi_red[15:0];
                raw_off_reg  <= raw_off_reg + TOTAL_W'(1);
                blk_left_reg <= blk_left_reg - BLK_W'(1);
            end
            else if (adv && hdr_emit && (hdr_reg == 3'd4))
                blk_left_reg <= blk_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (restart)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            out_byte_reg      <= byte_v;
            out_run_last_reg  <= item_done;
            out_file_last_reg <= file_done;
        end
    end

    assign stream.valid     = out_valid_reg;
    assign stream.out_byte  = out_byte_reg;
    assign stream.run_last  = out_run_last_reg;
    assign stream.file_last = out_file_last_reg;

    `ASSERT_ALWAYS(a_file_last_ends_item, clk, rst_n, !(out_valid_reg && out_file_last_reg) || out_run_last_reg, "file_last without run_last")
    `ASSERT_ALWAYS(a_block_has_data, clk, rst_n, !(phase_reg == PH_RAW && blk_left_reg == '0) || (geom.total > raw_off_reg), "stored block header past end of raw data")
    `ASSERT_ALWAYS(a_raw_complete, clk, rst_n, !(phase_reg == PH_TAIL && idx_reg == '0) || (raw_off_reg == geom.total), "trailer before all raw bytes")

endmodule
